>>> rtl/core/swsc_pkg.sv
`timescale 1ns / 1ps

package swsc_pkg;

    // Field widths
    localparam int WORD_W   = 32;
    localparam int ACTION_W = 2;
    localparam int KIND_W   = 2;
    localparam int SHIFT_W  = 4;

    // Header masks chosen by bit 0 of the random word
    localparam logic [WORD_W-1:0] HDR_ODD   = 32'hdf3d1b79;
    localparam logic [WORD_W-1:0] HDR_EVEN  = 32'h3ddf791b;
    // Index mixing constant
    localparam logic [WORD_W-1:0] MIX_CONST = 32'hf7fef7fe;
    // Shift pivot
    localparam logic [SHIFT_W-1:0] SHIFT_PIVOT = 4'd3;

    // Configuration register indexes
    typedef enum logic {
        CFG_MODE = 1'b0,
        CFG_SEED = 1'b1
    } t_cfg_idx;

    // Mode values
    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } t_mode;

    // Input item actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_BEGIN = 2'd0,
        ACT_CHECK = 2'd1,
        ACT_DATA  = 2'd2,
        ACT_END   = 2'd3
    } t_action;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_SUM    = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    // One result beat
    typedef struct packed {
        logic [WORD_W-1:0] word_out;
        t_kind             kind;
        logic              checksum_ok;
    } t_result;

    // Mask scramble after a data word, by word position
    function automatic logic [WORD_W-1:0] scramble_mask(
        input logic [WORD_W-1:0] mask,
        input logic [WORD_W-1:0] idx
    );
        logic [WORD_W-1:0]  times3;
        logic [WORD_W-1:0]  mixed;
        logic [SHIFT_W-1:0] lsh;
        logic [SHIFT_W-1:0] rsh;
        logic [WORD_W-1:0]  res;
        begin
            // idx * -3 modulo 2^32
            times3 = idx + {idx[WORD_W-2:0], 1'b0};
            mixed  = idx[1] ? (mask ^ (WORD_W'(0) - times3) ^ MIX_CONST) : mask;
            lsh    = SHIFT_PIVOT - idx[SHIFT_W-1:0];
            rsh    = idx[SHIFT_W-1:0] - SHIFT_PIVOT;
            if (idx[2]) begin
                res = (mixed << lsh) | WORD_W'($signed(mixed) >>> rsh);
            end else begin
                res = mixed;
            end
            return res;
        end
    endfunction

endpackage

>>> rtl/core/swsc_in_if.sv
`timescale 1ns / 1ps

interface swsc_in_if;
    import swsc_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [WORD_W-1:0]   word;

    modport source (output valid, output action, output word, input ready);
    modport sink   (input valid, input action, input word, output ready);

endinterface

>>> rtl/core/swsc_out_if.sv
`timescale 1ns / 1ps

interface swsc_out_if;
    import swsc_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word_out;
    logic [KIND_W-1:0] kind;
    logic              checksum_ok;

    modport source (output valid, output word_out, output kind, output checksum_ok,
                    input ready);
    modport sink   (input valid, input word_out, input kind, input checksum_ok,
                    output ready);

endinterface

>>> rtl/core/save_word_stream_cipher.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Beat contents
// i_item    in   valid/ready          action, word
// o_res     out  valid/ready          word_out, kind, checksum_ok
// cfg       in   i_cfg_we (no ready)  i_cfg_idx, i_cfg_data
//
// One beat in, one beat out; a new item is taken every cycle unless the skid
// register is full. Results load the output register, or the skid if stalled.
// The mask update (3*index add, xor, barrel shift) is the single logic stage
// between the state registers and the mask register.
// A skid register behind the output register keeps i_item.ready registered;
// input stalls only once both hold results.
// Synchronous active-low reset clears config, stream state and both valids.

module save_word_stream_cipher (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    swsc_in_if.sink                   i_item,
    swsc_out_if.source                o_res,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [swsc_pkg::WORD_W-1:0] i_cfg_data
);
    import swsc_pkg::*;

    // Config and stream state
    t_mode             r_mode;
    logic [WORD_W-1:0] r_seed;
    logic [WORD_W-1:0] r_mask, n_mask;
    logic [WORD_W-1:0] r_sum, n_sum;
    logic [WORD_W-1:0] r_exp, n_exp;
    logic [WORD_W-1:0] r_idx, n_idx;

    // Output register and skid
    logic    r_out_v, r_skid_v;
    t_result r_out, r_skid;
    t_result n_res;

    logic in_acc;
    logic out_free;

    assign i_item.ready = !r_skid_v;
    assign in_acc       = i_item.valid && !r_skid_v;
    assign out_free     = !r_out_v || o_res.ready;

    // Per-item processing
    always_comb begin
        logic [WORD_W-1:0] data_x;
        logic [WORD_W-1:0] cipher;
        logic [WORD_W-1:0] nm;
        n_mask = r_mask;
        n_sum  = r_sum;
        n_exp  = r_exp;
        n_idx  = r_idx;
        n_res  = '{word_out: '0, kind: KIND_NONE, checksum_ok: 1'b0};
        data_x = i_item.word ^ r_mask;
        cipher = (r_mode == MODE_ENCODE) ? data_x : i_item.word;
        nm     = cipher ^ r_seed;
        unique case (t_action'(i_item.action))
            ACT_BEGIN: begin
                n_sum = '0;
                n_idx = '0;
                if (r_mode == MODE_ENCODE) begin
                    n_mask = i_item.word ^ (i_item.word[0] ? HDR_ODD : HDR_EVEN);
                    n_res.word_out = n_mask;
                    n_res.kind     = KIND_HEADER;
                end else begin
                    n_mask = i_item.word;
                end
            end
            ACT_CHECK: begin
                n_exp = i_item.word;
            end
            ACT_DATA: begin
                n_sum          = r_sum ^ nm;
                n_mask         = scramble_mask(nm, r_idx);
                n_idx          = r_idx + WORD_W'(1);
                n_res.word_out = data_x;
                n_res.kind     = KIND_DATA;
            end
            ACT_END: begin
                n_res.word_out    = r_sum;
                n_res.kind        = KIND_SUM;
                n_res.checksum_ok = (r_mode == MODE_DECODE) && (r_sum == r_exp);
            end
            default: ;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENCODE;
            r_seed <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE: r_mode <= t_mode'(i_cfg_data[0]);
                CFG_SEED: r_seed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stream state update on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_sum  <= '0;
            r_exp  <= '0;
            r_idx  <= '0;
        end else if (in_acc) begin
            r_mask <= n_mask;
            r_sum  <= n_sum;
            r_exp  <= n_exp;
            r_idx  <= n_idx;
        end
    end

    // Output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            r_out_v  <= r_skid_v || in_acc;
            r_skid_v <= 1'b0;
        end else if (in_acc) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_v ? r_skid : n_res;
        end else if (in_acc) begin
            r_skid <= n_res;
        end
    end

    assign o_res.valid       = r_out_v;
    assign o_res.word_out    = r_out.word_out;
    assign o_res.kind        = r_out.kind;
    assign o_res.checksum_ok = r_out.checksum_ok;

    // Checks
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a result while the output register is empty");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_item.action == ACT_DATA) |=> (r_idx == $past(r_idx) + WORD_W'(1)))
        else $error("word index did not advance on a data beat");

    a_begin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_item.action == ACT_BEGIN) |=> (r_sum == '0 && r_idx == '0))
        else $error("begin did not clear checksum and index");

    a_none_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.kind == KIND_NONE) |-> (r_out.word_out == '0 && !r_out.checksum_ok))
        else $error("empty result carries data");

endmodule
